// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII converter.
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_VALUE_W     = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int FIFO_DEPTH     = 2;

    localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0]  CH_MINUS = 8'h2D;
    localparam logic [RADIX_W-1:0] DEC_BASE = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_RAW = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  mode;
        logic [RADIX_W-1:0]    radix;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic               raw;
        logic               neg;
        logic [RADIX_W-1:0] radix;
    } t_cmd_ctl;

    localparam int CTL_W = $bits(t_cmd_ctl);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIV,
        ST_RD,
        ST_LD,
        ST_SEND
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d8;
        d8 = CHAR_W'(d);
        if (d < DEC_BASE) begin
            return d8 + CH_ZERO;
        end else begin
            return d8 + CH_A - CHAR_W'(DEC_BASE);
        end
    endfunction

endpackage

// ===== rtl/integer_to_ascii_radix_top.sv =====
// Top level of the integer-to-ASCII radix converter.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
//   number: value, signed mode and radix. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns the characters, most significant digit
//   first, with last set on the final character of each number.
//   A front end classifies each word (raw byte, minus sign, base) and queues
//   it in a two-entry command queue, so new words are taken while the back
//   end is still converting; o_in_ready drops only when the queue is full.
//   The back end divides by the radix one quotient bit per cycle in a serial
//   divider, one digit per pass; digits are stacked in a small RAM, then
//   read back most significant first through the read, load and send
//   states. A raw byte goes straight to the output register.
//   Reset (i_rst_n low, synchronous) empties the queue and idles the back end.
//   If the receiver stalls, the current character is held in the output
//   register and conversion of the next number waits; the queue keeps
//   accepting words until it fills.
module integer_to_ascii_radix_top #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itoa_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output itoa_pkg::t_out_word o_out_data
);
    import itoa_pkg::*;

    localparam int CMD_W = CTL_W + VALUE_BITS;

    t_q_stat               w_q_stat;
    logic                  w_push;
    logic                  w_pop;
    t_cmd_ctl              w_f_ctl;
    logic [VALUE_BITS-1:0] w_f_mag;
    t_cmd_ctl              w_b_ctl;
    logic [VALUE_BITS-1:0] w_b_mag;
    logic [CMD_W-1:0]      w_q_head;

    itoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_word   (i_in_data),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_ctl    (w_f_ctl),
        .o_mag    (w_f_mag)
    );

    itoa_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_ctl, w_f_mag}),
        .i_pop   (w_pop),
        .o_data  (w_q_head),
        .o_stat  (w_q_stat)
    );

    assign w_b_ctl = w_q_head[CMD_W-1:VALUE_BITS];
    assign w_b_mag = w_q_head[VALUE_BITS-1:0];

    itoa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_ctl       (w_b_ctl),
        .i_mag       (w_b_mag),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // nothing is shown on the output straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid straight after reset");

    // once the last character of a number is taken, output valid drops
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last) |=> !o_out_valid)
        else $error("output valid directly after a last character");

    // an empty queue must always be able to take a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.empty |-> o_in_ready)
        else $error("input stalled with an empty queue");

    // the back end only pops when the queue holds a command
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from an empty queue");

endmodule

// ===== rtl/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH  = 6,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/itoa_front.sv =====
// Front end: accepts input words, classifies them and forms the magnitude.
module itoa_front #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                   i_valid,
    output logic                   o_ready,
    input  itoa_pkg::t_in_word     i_word,
    input  itoa_pkg::t_q_stat      i_q_stat,
    output logic                   o_push,
    output itoa_pkg::t_cmd_ctl     o_ctl,
    output logic [VALUE_BITS-1:0]  o_mag
);
    import itoa_pkg::*;

    localparam int EXT_W = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

    logic [EXT_W-1:0]      w_ext;
    logic [VALUE_BITS-1:0] w_val;
    logic                  w_raw;
    logic                  w_neg;

    assign w_ext = EXT_W'(i_word.value);
    assign w_val = w_ext[VALUE_BITS-1:0];

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        w_raw = (i_word.radix == RADIX_RAW);
        w_neg = i_word.mode && (i_word.radix == DEC_BASE) && w_val[VALUE_BITS-1];

        o_ctl.raw = w_raw;
        o_ctl.neg = w_neg;
        if (!w_raw && i_word.radix < RADIX_MIN) begin
            o_ctl.radix = DEC_BASE;   // base one runs as decimal
        end else begin
            o_ctl.radix = i_word.radix;
        end

        o_mag = w_neg ? (VALUE_BITS'(0) - w_val) : w_val;
    end

endmodule

// ===== rtl/itoa_fifo.sv =====
// Short command queue between front and back ends.
module itoa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = itoa_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output itoa_pkg::t_q_stat o_stat
);
    import itoa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/itoa_back.sv =====
// Back end: serial radix division, digit stack and character output register.
module itoa_back #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itoa_pkg::t_q_stat     i_q_stat,
    input  itoa_pkg::t_cmd_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output itoa_pkg::t_out_word   o_out_data
);
    import itoa_pkg::*;

    localparam int AW = $clog2(VALUE_BITS);
    localparam int SW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    t_back_state           r_state, n_state;
    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [RADIX_W-1:0]    r_rem, n_rem;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic [SW-1:0]         r_step, n_step;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic [RADIX_W:0]      w_rem_sh;
    logic [RADIX_W:0]      w_diff;
    logic                  w_ge;
    logic [RADIX_W-1:0]    w_rem_nx;
    logic [VALUE_BITS-1:0] w_q_nx;
    logic                  w_last_step;
    logic [CW-1:0]         w_cnt_m1;
    logic                  w_we;
    logic [RADIX_W-1:0]    w_rd_digit;

    // one quotient bit per cycle
    assign w_rem_sh    = {r_rem, r_q[VALUE_BITS-1]};
    assign w_diff      = w_rem_sh - {1'b0, r_radix};
    assign w_ge        = (w_rem_sh >= {1'b0, r_radix});
    assign w_rem_nx    = w_ge ? w_diff[RADIX_W-1:0] : w_rem_sh[RADIX_W-1:0];
    assign w_q_nx      = {r_q[VALUE_BITS-2:0], w_ge};
    assign w_last_step = (r_step == SW'(VALUE_BITS - 1));
    assign w_cnt_m1    = r_cnt - 1'b1;
    assign w_we        = (r_state == ST_DIV) && w_last_step;

    itoa_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_rem_nx),
        .i_raddr (w_cnt_m1[AW-1:0]),
        .o_rdata (w_rd_digit)
    );

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_q     = i_mag;
                    n_radix = i_ctl.radix;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    if (i_ctl.raw) begin
                        n_out.char_out = i_mag[CHAR_W-1:0];
                        n_out.last     = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = ST_SEND;
                    end else if (i_ctl.neg) begin
                        n_out.char_out = CH_MINUS;
                        n_out.last     = 1'b0;
                        n_out_valid    = 1'b1;
                        n_state        = ST_SIGN;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_SIGN: begin
                if (i_out_ready) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_q    = w_q_nx;
                n_rem  = w_rem_nx;
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_step = '0;
                    n_rem  = '0;
                    n_cnt  = r_cnt + 1'b1;
                    if (w_q_nx == '0) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LD;
            end
            ST_LD: begin
                n_out.char_out = digit_to_ascii(w_rd_digit);
                n_out.last     = (r_cnt == CW'(1));
                n_out_valid    = 1'b1;
                n_cnt          = w_cnt_m1;
                n_state        = ST_SEND;
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    n_state = r_out.last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
